>>> rtl/sorted_insert_table_unit_macros.svh
// Assertion helpers for the RTL (used by sit_table).
`ifndef SORTED_INSERT_TABLE_UNIT_MACROS_SVH
`define SORTED_INSERT_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SIT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sit assertion failed");

// Next-cycle implication, checked outside reset.
`define SIT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sit assertion failed");

`endif

>>> rtl/sit_pkg.sv
package sit_pkg;

   localparam int CAPACITY    = 16;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int PRICE_W     = 24;
   localparam int TAG_W       = 16;
   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 40;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_LISTED   = 2'd2,
      STATUS_NONE     = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_LIST = 1'b1
   } state_type;

   typedef struct packed {
      op_type              op;
      logic [PRICE_W-1:0]  price;
      logic [TAG_W-1:0]    tag;
      logic [PRICE_W-1:0]  limit;
      logic                list_all;
   } cmd_type;

endpackage

>>> rtl/sit_front.sv
module sit_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // price[23:0], tag[39:24], limit[63:40], list_all[64], zero pad [71:65]
   input  logic [sit_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd[0]
   input  logic                          req_tuser,
   output logic                          q_valid,
   input  logic                          q_ready,
   output sit_pkg::cmd_type              q_cmd
);
   import sit_pkg::*;

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   fill_ff, fill_in;
   cmd_type             decoded;
   logic                push, pop;

   // decode the incoming word into a command
   always_comb begin
      decoded.op       = req_tuser ? OP_QUERY : OP_INSERT;
      decoded.price    = req_tdata[PRICE_W-1:0];
      decoded.tag      = req_tdata[PRICE_W+TAG_W-1:PRICE_W];
      decoded.limit    = req_tdata[2*PRICE_W+TAG_W-1:PRICE_W+TAG_W];
      decoded.list_all = req_tdata[2*PRICE_W+TAG_W];
   end

   assign req_tready = (fill_ff != QCNT_W'(QUEUE_DEPTH));
   assign q_valid    = (fill_ff != '0);
   assign q_cmd      = slot_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

>>> rtl/sit_table.sv
module sit_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   output logic                          q_ready,
   input  sit_pkg::cmd_type              q_cmd,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // entry_price[23:0], entry_tag[39:24]
   output logic [sit_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]                    rsp_tuser,
   output logic                          rsp_tlast
);
   import sit_pkg::*;

   `include "sorted_insert_table_unit_macros.svh"

   // sorted cells
   logic [PRICE_W-1:0] price_ff [CAPACITY];
   logic [PRICE_W-1:0] price_in [CAPACITY];
   logic [TAG_W-1:0]   tag_ff   [CAPACITY];
   logic [TAG_W-1:0]   tag_in   [CAPACITY];
   logic [CNT_W-1:0]   count_ff, count_in;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [PRICE_W-1:0] limit_ff, limit_in;
   logic               all_ff, all_in;

   logic               out_valid_ff, out_valid_in;
   status_type         out_status_ff, out_status_in;
   logic [PRICE_W-1:0] out_price_ff, out_price_in;
   logic [TAG_W-1:0]   out_tag_ff, out_tag_in;
   logic               out_last_ff, out_last_in;

   logic [CAPACITY-1:0] at_or_after;   // cell index >= insert position
   logic [CAPACITY-1:0] match;
   logic [CAPACITY-1:0] match_next;
   logic                slot_free;
   logic                do_insert;
   logic                full;

   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign slot_free = !out_valid_ff || rsp_tready;

   // insert position: first valid cell above the new price, else the tail
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         at_or_after[i] = (CNT_W'(i) >= count_ff) || (price_ff[i] > q_cmd.price);
      end
   end

   // cells shift up from the insert position; the new entry drops in there
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         price_in[i] = price_ff[i];
         tag_in[i]   = tag_ff[i];
         if (do_insert && at_or_after[i]) begin
            if (i > 0 && at_or_after[(i > 0) ? i - 1 : 0]) begin
               price_in[i] = price_ff[(i > 0) ? i - 1 : 0];
               tag_in[i]   = tag_ff[(i > 0) ? i - 1 : 0];
            end else begin
               price_in[i] = q_cmd.price;
               tag_in[i]   = q_cmd.tag;
            end
         end
      end
   end

   // table is sorted, so matches form a prefix
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match[i] = (CNT_W'(i) < count_ff) && (all_ff || (price_ff[i] < limit_ff));
      end
      match_next = match >> 1;
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      limit_in      = limit_ff;
      all_in        = all_ff;
      count_in      = count_ff;
      q_ready       = 1'b0;
      do_insert     = 1'b0;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_status_in = out_status_ff;
      out_price_in  = out_price_ff;
      out_tag_in    = out_tag_ff;
      out_last_in   = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            q_ready = slot_free;
            if (q_valid && slot_free) begin
               if (q_cmd.op == OP_INSERT) begin
                  out_valid_in = 1'b1;
                  out_price_in = '0;
                  out_tag_in   = '0;
                  out_last_in  = 1'b1;
                  if (full) begin
                     out_status_in = STATUS_FULL;
                  end else begin
                     out_status_in = STATUS_INSERTED;
                     do_insert     = 1'b1;
                     count_in      = count_ff + 1'b1;
                  end
               end else begin
                  limit_in = q_cmd.limit;
                  all_in   = q_cmd.list_all;
                  idx_in   = '0;
                  state_in = ST_LIST;
               end
            end
         end
         ST_LIST: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               if (!match[idx_ff]) begin
                  // only reachable on the first step: table empty or nothing below the limit
                  out_status_in = STATUS_NONE;
                  out_price_in  = '0;
                  out_tag_in    = '0;
                  out_last_in   = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  out_status_in = STATUS_LISTED;
                  out_price_in  = price_ff[idx_ff];
                  out_tag_in    = tag_ff[idx_ff];
                  out_last_in   = !match_next[idx_ff];
                  if (!match_next[idx_ff]) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      price_ff      <= price_in;
      tag_ff        <= tag_in;
      idx_ff        <= idx_in;
      limit_ff      <= limit_in;
      all_ff        <= all_in;
      out_status_ff <= out_status_in;
      out_price_ff  <= out_price_in;
      out_tag_ff    <= out_tag_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_tag_ff, out_price_ff};
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

   `SIT_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `SIT_ASSERT_NEXT(a_insert_grows, clock, reset, do_insert, count_ff == $past(count_ff) + 1'b1)
   `SIT_ASSERT_NOW(a_no_pop_in_list, clock, reset, state_ff == ST_LIST, !q_ready)
   `SIT_ASSERT_NOW(a_full_no_write, clock, reset, full, !do_insert)

endmodule

>>> rtl/sorted_insert_table_unit.sv
// Insert result: the word is registered in the queue, then in the table's output register.
// Query: the limit is latched first, then one result per cycle while the receiver is ready, up to 16.
// Throughput: insert 1 word/cycle while the receiver is ready; a query holds the table until its last result.
// Table sequencer handles one command at a time; 2-deep queue decouples intake.
// Reset: synchronous, active high; empties table, queue and output register.
module sorted_insert_table_unit (
   input  logic                          clock,
   input  logic                          reset,
   // request stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // price[23:0], tag[39:24], limit[63:40], list_all[64], zero pad [71:65]
   input  logic [sit_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd[0]: 0 insert, 1 query
   input  logic                          req_tuser,
   // response stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // entry_price[23:0], entry_tag[39:24]
   output logic [sit_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0]: 0 inserted, 1 full, 2 listed entry, 3 none found
   output logic [1:0]                    rsp_tuser,
   // last word caused by the request
   output logic                          rsp_tlast
);
   import sit_pkg::*;

   // front end -> back end command queue
   logic    q_valid;
   logic    q_ready;
   cmd_type q_cmd;

   // front: decodes request words and buffers them
   sit_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_cmd      (q_cmd)
   );

   // back: sorted cells, list sequencer and output register
   sit_table u_table (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_cmd      (q_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> verif/tb_sorted_insert_table_unit.sv
module tb_sorted_insert_table_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import sit_pkg::*;

   // Cycles with no word moving on either side before the run is called hung.
   // Neither a full listing nor a run of 53% receiver stalls comes close to it,
   // so this is far above any correct run.
   localparam int WATCHDOG_LIMIT   = 2000;
   // Settle time after the last response: one more full listing and then some.
   localparam int TAIL_CYCLES      = 2 * CAPACITY + 8;
   localparam int WORDS_PER_PHASE  = 32;
   localparam int INSERT_PCT       = 15;
   localparam int MISMATCH_REPORTS = 10;

   localparam logic [PRICE_W-1:0] PRICE_MAX = '1;
   localparam logic [PRICE_W-1:0] PRICE_MID = 24'h800000;

   // One response word as the block should produce it.
   typedef struct packed {
      status_type          status;
      logic [PRICE_W-1:0]  price;
      logic [TAG_W-1:0]    tag;
      logic                is_last;
   } table_result_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // price[23:0], tag[39:24], limit[63:40], list_all[64], zero pad [71:65]
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   // cmd[0]
   logic                   req_tuser  = OP_INSERT;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // entry_price[23:0], entry_tag[39:24]
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   // status[1:0]
   logic [1:0]             rsp_tuser;
   logic                   rsp_tlast;

   // Shadow copy of the sorted book, kept by the predictor.
   logic [PRICE_W-1:0]     book_price [CAPACITY];
   logic [TAG_W-1:0]       book_tag   [CAPACITY];
   int                     book_count = 0;

   table_result_type       pending_results [$];
   int                     mismatch_count = 0;
   int                     stalled_cycles = 0;
   int                     idle_pct       = 0;
   int                     recv_stall_pct = 0;

   sorted_insert_table_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor: sorted insert with stable order among equal prices, and a
   // listing of entries strictly below the limit (or all of them).
   // ---------------------------------------------------------------------
   function automatic void push_result(status_type status, logic [PRICE_W-1:0] price,
                                       logic [TAG_W-1:0] tag, logic is_last);
      table_result_type r;
      r.status  = status;
      r.price   = price;
      r.tag     = tag;
      r.is_last = is_last;
      pending_results.push_back(r);
   endfunction

   function automatic void predict_word(op_type op, logic [PRICE_W-1:0] price,
                                        logic [TAG_W-1:0] tag, logic [PRICE_W-1:0] limit,
                                        logic list_all);
      int pos;
      int hits;
      int sent;
      pos  = book_count;
      hits = 0;
      sent = 0;
      if (op == OP_INSERT) begin
         if (book_count >= CAPACITY) begin
            // book full: entry dropped, contents untouched
            push_result(STATUS_FULL, '0, '0, 1'b1);
         end else begin
            // first strictly higher price; equal prices stay ahead of the new one
            for (int i = 0; i < book_count; i++)
               if (book_price[i] > price && pos == book_count)
                  pos = i;
            for (int i = book_count; i > pos; i--) begin
               book_price[i] = book_price[i-1];
               book_tag[i]   = book_tag[i-1];
            end
            book_price[pos] = price;
            book_tag[pos]   = tag;
            book_count++;
            push_result(STATUS_INSERTED, '0, '0, 1'b1);
         end
      end else begin
         for (int i = 0; i < book_count; i++)
            if (list_all || book_price[i] < limit)
               hits++;
         if (hits == 0) begin
            // empty book or nothing below the limit
            push_result(STATUS_NONE, '0, '0, 1'b1);
         end else begin
            for (int i = 0; i < book_count; i++)
               if (list_all || book_price[i] < limit) begin
                  sent++;
                  push_result(STATUS_LISTED, book_price[i], book_tag[i], sent == hits);
               end
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // Response side: random backpressure and in-order field check.
   // ---------------------------------------------------------------------
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   function automatic void report_mismatch(string what, table_result_type want,
                                           table_result_type got);
      mismatch_count++;
      if (mismatch_count <= MISMATCH_REPORTS)
         $display("%0t: %s: expected status %0d price %h tag %h last %b, %s %0d %s %h %s %h %s %b",
                  $realtime, what, want.status, want.price, want.tag, want.is_last,
                  "got status", got.status, "price", got.price, "tag", got.tag,
                  "last", got.is_last);
   endfunction

   always @(posedge clock) begin : check_rsp
      table_result_type want;
      table_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status  = status_type'(rsp_tuser);
         got.price   = rsp_tdata[PRICE_W-1:0];
         got.tag     = rsp_tdata[PRICE_W+TAG_W-1:PRICE_W];
         got.is_last = rsp_tlast;
         if (pending_results.size() == 0) begin
            report_mismatch("word with nothing pending", '0, got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want)
               report_mismatch("response mismatch", want, got);
         end
      end
   end

   // Hang detector: no word moved on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles == WATCHDOG_LIMIT) begin
         $display("sorted_insert_table_unit regression: fail");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Request side.
   // ---------------------------------------------------------------------
   // Drives one word, with an optional random gap in front of it, and predicts it once
   // taken. valid stays high into the next word unless a gap follows.
   task automatic send_word(input op_type op, input logic [PRICE_W-1:0] price,
                            input logic [TAG_W-1:0] tag, input logic [PRICE_W-1:0] limit,
                            input logic list_all);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, list_all, limit, tag, price};
      do @(posedge clock); while (!req_tready);
      predict_word(op, price, tag, limit, list_all);
   endtask

   // Hold off the sender until every pending response is back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Mix of tiny values (lots of equal prices), a mid cluster, the extremes
   // and the full range.
   function automatic logic [PRICE_W-1:0] rand_price();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(4))
         0: return PRICE_W'($urandom_range(15));
         1: return PRICE_MID + PRICE_W'($urandom_range(3));
         2: return r[0] ? PRICE_MAX : '0;
         default: return r[PRICE_W-1:0];
      endcase
   endfunction

   // When the book is not empty, half the limits sit on or next to a stored price to work the strict compare.
   function automatic logic [PRICE_W-1:0] rand_limit();
      if (book_count > 0 && $urandom_range(1) == 0)
         return book_price[$urandom_range(book_count - 1)] + PRICE_W'($urandom_range(2))
                - PRICE_W'(1);
      return rand_price();
   endfunction

   // ---------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------
   // Nothing stored yet: every query form answers none found.
   task automatic test_empty_table();
      send_word(OP_QUERY, '0, '0, PRICE_MAX, 1'b0);
      send_word(OP_QUERY, '0, '0, PRICE_MAX, 1'b1);
      send_word(OP_QUERY, PRICE_MAX, '1, '0, 1'b0);
   endtask

   // Extreme prices, the top tag, out-of-order arrival, and equal prices that
   // must keep arrival order.
   task automatic test_insert_order();
      send_word(OP_INSERT, 24'h000100, 16'h0001, '0, 1'b0);
      send_word(OP_INSERT, PRICE_MAX, 16'h0002, PRICE_MAX, 1'b1);
      send_word(OP_INSERT, '0, 16'h0003, '0, 1'b0);
      send_word(OP_INSERT, 24'h000100, 16'h0004, '0, 1'b0);
      send_word(OP_INSERT, 24'h000100, 16'h0005, '0, 1'b0);
      send_word(OP_INSERT, 24'h000080, '1, '0, 1'b0);
   endtask

   // Limit zero with and without list_all, limits on and just past a stored
   // price, and the top limit that still excludes the top price.
   task automatic test_query_limits();
      send_word(OP_QUERY, '0, '0, '0, 1'b0);
      send_word(OP_QUERY, '0, '0, '0, 1'b1);
      send_word(OP_QUERY, '0, '0, 24'h000100, 1'b0);
      send_word(OP_QUERY, '0, '0, 24'h000101, 1'b0);
      send_word(OP_QUERY, '0, '0, PRICE_MAX, 1'b0);
      send_word(OP_QUERY, '0, '0, 24'h000001, 1'b0);
   endtask

   // Mostly queries, with inserts rare enough that the book fills slowly and
   // listings of every length show up along the way.
   task automatic run_random_phase(input int send_pct, input int stall_pct, input int words);
      logic [31:0] noise;
      idle_pct       = send_pct;
      recv_stall_pct = stall_pct;
      repeat (words) begin
         noise = $urandom;
         if ($urandom_range(99) < INSERT_PCT)
            send_word(OP_INSERT, rand_price(), noise[TAG_W-1:0], rand_price(), noise[TAG_W]);
         else
            send_word(OP_QUERY, rand_price(), noise[TAG_W-1:0], rand_limit(),
                      $urandom_range(3) == 0);
      end
   endtask

   // Top the book up, then overflow it, list all CAPACITY entries and query with the top and zero limits.
   task automatic test_table_full();
      logic [31:0] noise;
      idle_pct       = 0;
      recv_stall_pct = 0;
      while (book_count < CAPACITY) begin
         noise = $urandom;
         send_word(OP_INSERT, rand_price(), noise[TAG_W-1:0], '0, 1'b0);
      end
      send_word(OP_INSERT, '0, '0, '0, 1'b0);
      send_word(OP_INSERT, PRICE_MAX, '1, PRICE_MAX, 1'b1);
      send_word(OP_INSERT, PRICE_MID, 16'h5a5a, '0, 1'b0);
      send_word(OP_QUERY, '0, '0, '0, 1'b1);
      send_word(OP_QUERY, '0, '0, PRICE_MAX, 1'b0);
      send_word(OP_QUERY, '0, '0, '0, 1'b0);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_insert_order();
      test_query_limits();
      wait_drained();

      // back-to-back, sender gaps, receiver stalls, then a light mix of both
      run_random_phase(0, 0, WORDS_PER_PHASE);
      wait_drained();
      run_random_phase(53, 0, WORDS_PER_PHASE);
      run_random_phase(0, 53, WORDS_PER_PHASE);
      wait_drained();
      run_random_phase(10, 10, WORDS_PER_PHASE);

      test_table_full();
      wait_drained();
      // catch stray words after the last expected one
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("sorted_insert_table_unit regression: pass");
      else
         $display("sorted_insert_table_unit regression: fail");
      $finish;
   end

endmodule
